/* hw/rtl/cst_pkg.sv */
// cst_pkg: shared types, token kind codes and keyword table for the token scanner
// no dependencies

package cst_pkg;

   localparam int LINE_BITS_DEF   = 16;
   localparam int LENGTH_BITS_DEF = 16;
   localparam int MAX_RECS        = 4;
   localparam int WORD_DEPTH      = 7;
   localparam int NUM_KW          = 12;

   // token kinds
   localparam logic [5:0] K_FLOAT   = 6'd0;
   localparam logic [5:0] K_NUMBER  = 6'd1;
   localparam logic [5:0] K_STRING  = 6'd2;
   localparam logic [5:0] K_KW0     = 6'd3;
   localparam logic [5:0] K_IDENT   = 6'd15;
   localparam logic [5:0] K_INC     = 6'd16;
   localparam logic [5:0] K_PLUS    = 6'd17;
   localparam logic [5:0] K_DEC     = 6'd18;
   localparam logic [5:0] K_MINUS   = 6'd19;
   localparam logic [5:0] K_STAR    = 6'd20;
   localparam logic [5:0] K_SLASH   = 6'd21;
   localparam logic [5:0] K_PCT     = 6'd22;
   localparam logic [5:0] K_EQEQ    = 6'd23;
   localparam logic [5:0] K_ASSIGN  = 6'd24;
   localparam logic [5:0] K_NEQ     = 6'd25;
   localparam logic [5:0] K_NOT     = 6'd26;
   localparam logic [5:0] K_LE      = 6'd27;
   localparam logic [5:0] K_SHL     = 6'd28;
   localparam logic [5:0] K_LT      = 6'd29;
   localparam logic [5:0] K_GE      = 6'd30;
   localparam logic [5:0] K_GT      = 6'd31;
   localparam logic [5:0] K_ANDAND  = 6'd32;
   localparam logic [5:0] K_UNKNOWN = 6'd33;
   localparam logic [5:0] K_OROR    = 6'd34;
   localparam logic [5:0] K_LPAREN  = 6'd35;
   localparam logic [5:0] K_RPAREN  = 6'd36;
   localparam logic [5:0] K_LBRACE  = 6'd37;
   localparam logic [5:0] K_RBRACE  = 6'd38;
   localparam logic [5:0] K_SEMI    = 6'd39;
   localparam logic [5:0] K_COMMA   = 6'd40;
   localparam logic [5:0] K_HASH    = 6'd41;
   localparam logic [5:0] K_DOT     = 6'd42;
   localparam logic [5:0] K_EOF     = 6'd43;

   // record type codes
   localparam logic REC_TEXT = 1'b0;
   localparam logic REC_END  = 1'b1;

   typedef logic [WORD_DEPTH-1:0][7:0] word_type;

   localparam word_type KW_TEXT [NUM_KW] = '{
      {8'h00, 8'h00, 8'h00, 8'h00, "t", "n", "i"},
      {8'h00, 8'h00, "t", "a", "o", "l", "f"},
      {8'h00, 8'h00, 8'h00, "l", "o", "o", "b"},
      {8'h00, 8'h00, 8'h00, "e", "u", "r", "t"},
      {8'h00, 8'h00, "e", "s", "l", "a", "f"},
      {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, "f", "i"},
      {8'h00, 8'h00, 8'h00, "e", "s", "l", "e"},
      {8'h00, 8'h00, 8'h00, "t", "u", "o", "c"},
      {8'h00, 8'h00, 8'h00, "l", "d", "n", "e"},
      {"e", "d", "u", "l", "c", "n", "i"},
      {8'h00, 8'h00, 8'h00, "n", "i", "a", "m"},
      {8'h00, "n", "r", "u", "t", "e", "r"}
   };
   localparam logic [3:0] KW_LEN [NUM_KW] = '{
      4'd3, 4'd5, 4'd4, 4'd4, 4'd5, 4'd2, 4'd4, 4'd4, 4'd4, 4'd7, 4'd4, 4'd6
   };

   typedef struct packed {
      logic        rtype;
      logic [7:0]  tb;
      logic [5:0]  kind;
      logic [15:0] line;
      logic [15:0] len;
   } rec_type;

   typedef struct packed {
      logic [2:0]                  cnt;
      rec_type [MAX_RECS-1:0]      recs;
   } bundle_type;

   function automatic logic [5:0] word_kind(input word_type w, input logic [3:0] n);
      logic [5:0] k;
      logic       hit;
      k = K_IDENT;
      for (int i = NUM_KW - 1; i >= 0; i--) begin
         hit = (KW_LEN[i] == n);
         for (int j = 0; j < WORD_DEPTH; j++) begin
            if (4'(j) < n && w[j] != KW_TEXT[i][j]) hit = 1'b0;
         end
         if (hit) k = 6'(int'(K_KW0) + i);
      end
      return k;
   endfunction

   function automatic logic [5:0] single_kind(input logic [7:0] c);
      logic [5:0] k;
      case (c)
         "+": k = K_PLUS;
         "-": k = K_MINUS;
         "*": k = K_STAR;
         "/": k = K_SLASH;
         "%": k = K_PCT;
         "=": k = K_ASSIGN;
         "!": k = K_NOT;
         "<": k = K_LT;
         ">": k = K_GT;
         "(": k = K_LPAREN;
         ")": k = K_RPAREN;
         "{": k = K_LBRACE;
         "}": k = K_RBRACE;
         ";": k = K_SEMI;
         ",": k = K_COMMA;
         "#": k = K_HASH;
         ".": k = K_DOT;
         default: k = K_UNKNOWN;
      endcase
      return k;
   endfunction

   // pair match: valid flag in bit 6
   function automatic logic [6:0] pair_kind(input logic [7:0] h, input logic [7:0] b);
      logic [6:0] r;
      r = '0;
      if (h == "+" && b == "+") r = {1'b1, K_INC};
      if (h == "-" && b == "-") r = {1'b1, K_DEC};
      if (h == "=" && b == "=") r = {1'b1, K_EQEQ};
      if (h == "!" && b == "=") r = {1'b1, K_NEQ};
      if (h == "<" && b == "=") r = {1'b1, K_LE};
      if (h == "<" && b == "<") r = {1'b1, K_SHL};
      if (h == ">" && b == "=") r = {1'b1, K_GE};
      if (h == "&" && b == "&") r = {1'b1, K_ANDAND};
      if (h == "|" && b == "|") r = {1'b1, K_OROR};
      return r;
   endfunction

endpackage

/* hw/rtl/cst_if.sv */
// cst_req_if, cst_rsp_if: request and result channels of the token scanner
// depends on nothing

interface cst_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_input;
   modport source (output valid, in_byte, end_of_input, input ready);
   modport sink   (input valid, in_byte, end_of_input, output ready);
endinterface

interface cst_rsp_if;
   logic        valid;
   logic        ready;
   logic        record_type;
   logic [7:0]  text_byte;
   logic [5:0]  token_kind;
   logic [15:0] start_line;
   logic [15:0] text_length;
   logic        last;
   modport source (output valid, record_type, text_byte, token_kind, start_line,
                   text_length, last, input ready);
   modport sink   (input valid, record_type, text_byte, token_kind, start_line,
                   text_length, last, output ready);
endinterface

/* hw/rtl/cst_front.sv */
// cst_front: scanner state machine, one byte per cycle while the queue is not full, builds a bundle of records
// depends on cst_pkg

module cst_front #(
   parameter int LINE_BITS   = 16,
   parameter int LENGTH_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic [7:0]           in_byte,
   input  logic                 in_eoi,
   input  logic                 q_full,
   output logic                 in_ready,
   output logic                 push,
   output cst_pkg::bundle_type  push_data
);
   import cst_pkg::*;

   localparam logic [3:0] M_IDLE   = 4'd0;
   localparam logic [3:0] M_NUM    = 4'd1;
   localparam logic [3:0] M_WORD   = 4'd2;
   localparam logic [3:0] M_STR    = 4'd3;
   localparam logic [3:0] M_STR_BS = 4'd4;
   localparam logic [3:0] M_LCMT   = 4'd5;
   localparam logic [3:0] M_BCMT   = 4'd6;
   localparam logic [3:0] M_BSTAR  = 4'd7;
   localparam logic [3:0] M_SLASH  = 4'd8;
   localparam logic [3:0] M_OP     = 4'd9;

   localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;
   localparam logic [LENGTH_BITS-1:0] LEN_MAX  = '1;
   localparam logic [LINE_BITS-1:0]   LINE_ONE = LINE_BITS'(1);

   logic [3:0]             mode_ff, mode_in;
   logic [7:0]             held_ff, held_in;
   logic                   dot_ff, dot_in;
   word_type               letters_ff, letters_in;
   logic [3:0]             wcnt_ff, wcnt_in;
   logic [LINE_BITS-1:0]   line_ff, line_in;
   logic [LINE_BITS-1:0]   tline_ff, tline_in;
   logic [LENGTH_BITS-1:0] tcnt_ff, tcnt_in;
   rec_type [MAX_RECS-1:0] recs;
   logic [2:0]             n;
   logic                   go_idle;
   logic [6:0]             pk;
   logic                   accept;

   function automatic logic [15:0] line16(input logic [LINE_BITS-1:0] x);
      logic [31:0] w;
      w = 32'(x);
      return w[15:0];
   endfunction

   function automatic logic [15:0] len16(input logic [LENGTH_BITS-1:0] x);
      logic [31:0] w;
      w = 32'(x);
      return w[15:0];
   endfunction

   function automatic rec_type text_rec(input logic [7:0] b);
      rec_type r;
      r = '0;
      r.rtype = REC_TEXT;
      r.tb = b;
      return r;
   endfunction

   function automatic rec_type end_rec(input logic [5:0] k, input logic [15:0] ln,
                                       input logic [15:0] len);
      rec_type r;
      r = '0;
      r.rtype = REC_END;
      r.kind = k;
      r.line = ln;
      r.len = len;
      return r;
   endfunction

   function automatic logic is_space(input logic [7:0] b);
      return b == " " || (b >= 8'd9 && b <= 8'd13);
   endfunction

   function automatic logic is_digit(input logic [7:0] b);
      return b >= "0" && b <= "9";
   endfunction

   function automatic logic is_alpha(input logic [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
   endfunction

   function automatic logic holds_pair(input logic [7:0] b);
      return b == "+" || b == "-" || b == "=" || b == "!" ||
             b == "<" || b == ">" || b == "&" || b == "|";
   endfunction

   assign in_ready = !q_full;
   assign accept   = in_valid && in_ready;

   // one scanner step
   always_comb begin
      mode_in = mode_ff; held_in = held_ff; dot_in = dot_ff; letters_in = letters_ff;
      wcnt_in = wcnt_ff; line_in = line_ff; tline_in = tline_ff; tcnt_in = tcnt_ff;
      recs = '0; n = '0; go_idle = 1'b0;
      pk = pair_kind(held_ff, in_byte);
      if (in_eoi) begin
         // flush the pending token
         case (mode_ff)
            M_NUM: begin
               recs[n[1:0]] = end_rec(dot_ff ? K_FLOAT : K_NUMBER, line16(tline_in),
                                      len16(tcnt_in));
               n = n + 3'd1;
            end
            M_WORD: begin
               recs[n[1:0]] = end_rec(word_kind(letters_ff, wcnt_ff), line16(tline_in),
                                      len16(tcnt_in));
               n = n + 3'd1;
            end
            M_STR: begin
               recs[n[1:0]] = end_rec(K_STRING, line16(tline_in), len16(tcnt_in));
               n = n + 3'd1;
            end
            M_STR_BS: begin
               recs[n[1:0]] = text_rec("\\"); n = n + 3'd1;
               if (tcnt_in != LEN_MAX) tcnt_in = tcnt_in + 1'b1;
               recs[n[1:0]] = end_rec(K_STRING, line16(tline_in), len16(tcnt_in));
               n = n + 3'd1;
            end
            M_SLASH: begin
               recs[n[1:0]] = text_rec("/"); n = n + 3'd1;
               if (tcnt_in != LEN_MAX) tcnt_in = tcnt_in + 1'b1;
               recs[n[1:0]] = end_rec(K_SLASH, line16(tline_in), len16(tcnt_in));
               n = n + 3'd1;
            end
            M_OP: begin
               recs[n[1:0]] = text_rec(held_ff); n = n + 3'd1;
               if (tcnt_in != LEN_MAX) tcnt_in = tcnt_in + 1'b1;
               recs[n[1:0]] = end_rec(single_kind(held_ff), line16(tline_in),
                                      len16(tcnt_in));
               n = n + 3'd1;
            end
            default: ;
         endcase
         recs[n[1:0]] = end_rec(K_EOF, line16(line_ff), 16'd0);
         n = n + 3'd1;
         mode_in = M_IDLE; held_in = '0; dot_in = 1'b0; wcnt_in = '0;
         line_in = LINE_ONE; tline_in = LINE_ONE; tcnt_in = '0;
      end else begin
         if (in_byte == 8'd10 && line_in != LINE_MAX) line_in = line_in + 1'b1;
         case (mode_ff)
            M_NUM: begin
               if (is_digit(in_byte) || in_byte == ".") begin
                  if (in_byte == ".") dot_in = 1'b1;
                  recs[n[1:0]] = text_rec(in_byte); n = n + 3'd1;
                  if (tcnt_in != LEN_MAX) tcnt_in = tcnt_in + 1'b1;
               end else begin
                  recs[n[1:0]] = end_rec(dot_ff ? K_FLOAT : K_NUMBER, line16(tline_in),
                                         len16(tcnt_in));
                  n = n + 3'd1;
                  go_idle = 1'b1;
               end
            end
            M_WORD: begin
               if (is_alpha(in_byte) || is_digit(in_byte) || in_byte == "_") begin
                  if (wcnt_in < 4'd7) letters_in[wcnt_in[2:0]] = in_byte;
                  if (wcnt_in < 4'd8) wcnt_in = wcnt_in + 4'd1;
                  recs[n[1:0]] = text_rec(in_byte); n = n + 3'd1;
                  if (tcnt_in != LEN_MAX) tcnt_in = tcnt_in + 1'b1;
               end else begin
                  recs[n[1:0]] = end_rec(word_kind(letters_ff, wcnt_ff), line16(tline_in),
                                         len16(tcnt_in));
                  n = n + 3'd1;
                  go_idle = 1'b1;
               end
            end
            M_STR, M_STR_BS: begin
               mode_in = M_STR;
               if (mode_ff == M_STR_BS && in_byte == "n") begin
                  recs[n[1:0]] = text_rec(8'd10); n = n + 3'd1;
                  if (tcnt_in != LEN_MAX) tcnt_in = tcnt_in + 1'b1;
               end else begin
                  if (mode_ff == M_STR_BS) begin
                     recs[n[1:0]] = text_rec("\\"); n = n + 3'd1;
                     if (tcnt_in != LEN_MAX) tcnt_in = tcnt_in + 1'b1;
                  end
                  if (in_byte == "\"") begin
                     recs[n[1:0]] = end_rec(K_STRING, line16(tline_in), len16(tcnt_in));
                     n = n + 3'd1;
                     mode_in = M_IDLE;
                  end else if (in_byte == "\\") begin
                     mode_in = M_STR_BS;
                  end else begin
                     recs[n[1:0]] = text_rec(in_byte); n = n + 3'd1;
                     if (tcnt_in != LEN_MAX) tcnt_in = tcnt_in + 1'b1;
                  end
               end
            end
            M_LCMT: if (in_byte == 8'd10) mode_in = M_IDLE;
            M_BCMT: if (in_byte == "*") mode_in = M_BSTAR;
            M_BSTAR: begin
               if (in_byte == "/") mode_in = M_IDLE;
               else if (in_byte != "*") mode_in = M_BCMT;
            end
            M_SLASH: begin
               if (in_byte == "/") mode_in = M_LCMT;
               else if (in_byte == "*") mode_in = M_BCMT;
               else begin
                  recs[n[1:0]] = text_rec("/"); n = n + 3'd1;
                  if (tcnt_in != LEN_MAX) tcnt_in = tcnt_in + 1'b1;
                  recs[n[1:0]] = end_rec(K_SLASH, line16(tline_in), len16(tcnt_in));
                  n = n + 3'd1;
                  go_idle = 1'b1;
               end
            end
            M_OP: begin
               recs[n[1:0]] = text_rec(held_ff); n = n + 3'd1;
               if (tcnt_in != LEN_MAX) tcnt_in = tcnt_in + 1'b1;
               if (pk[6]) begin
                  recs[n[1:0]] = text_rec(in_byte); n = n + 3'd1;
                  if (tcnt_in != LEN_MAX) tcnt_in = tcnt_in + 1'b1;
                  recs[n[1:0]] = end_rec(pk[5:0], line16(tline_in), len16(tcnt_in));
                  n = n + 3'd1;
                  mode_in = M_IDLE;
               end else begin
                  recs[n[1:0]] = end_rec(single_kind(held_ff), line16(tline_in),
                                         len16(tcnt_in));
                  n = n + 3'd1;
                  go_idle = 1'b1;
               end
            end
            default: go_idle = 1'b1;
         endcase

         // classify a byte seen between tokens
         if (go_idle) begin
            mode_in = M_IDLE;
            if (!is_space(in_byte)) begin
               tcnt_in = '0;
               tline_in = line_in;
               if (in_byte == "/") begin
                  mode_in = M_SLASH;
               end else if (in_byte == "\"") begin
                  mode_in = M_STR;
               end else if (is_digit(in_byte)) begin
                  dot_in = 1'b0;
                  recs[n[1:0]] = text_rec(in_byte); n = n + 3'd1;
                  tcnt_in = LENGTH_BITS'(1);
                  mode_in = M_NUM;
               end else if (is_alpha(in_byte) || in_byte == "_") begin
                  letters_in[0] = in_byte;
                  wcnt_in = 4'd1;
                  recs[n[1:0]] = text_rec(in_byte); n = n + 3'd1;
                  tcnt_in = LENGTH_BITS'(1);
                  mode_in = M_WORD;
               end else if (holds_pair(in_byte)) begin
                  held_in = in_byte;
                  mode_in = M_OP;
               end else begin
                  recs[n[1:0]] = text_rec(in_byte); n = n + 3'd1;
                  tcnt_in = LENGTH_BITS'(1);
                  recs[n[1:0]] = end_rec(single_kind(in_byte), line16(tline_in),
                                         len16(tcnt_in));
                  n = n + 3'd1;
               end
            end
         end
      end
   end

   assign push           = accept && (n != 3'd0);
   assign push_data.cnt  = n;
   assign push_data.recs = recs;

   // scanner state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= M_IDLE;
         held_ff <= '0;
         dot_ff <= 1'b0;
         wcnt_ff <= '0;
         line_ff <= LINE_ONE;
         tline_ff <= LINE_ONE;
         tcnt_ff <= '0;
      end else if (accept) begin
         mode_ff <= mode_in;
         held_ff <= held_in;
         dot_ff <= dot_in;
         wcnt_ff <= wcnt_in;
         line_ff <= line_in;
         tline_ff <= tline_in;
         tcnt_ff <= tcnt_in;
      end
   end

   // word letters, written before read within a word
   always_ff @(posedge clock) begin
      if (accept) letters_ff <= letters_in;
   end

   a_line_nonzero: assert property (@(posedge clock) disable iff (reset)
      line_ff != '0) else $error("line count dropped to zero");
   a_wcnt_range: assert property (@(posedge clock) disable iff (reset)
      wcnt_ff <= 4'd8) else $error("word count out of range");
   a_push_cnt: assert property (@(posedge clock) disable iff (reset)
      push |-> n <= 3'(MAX_RECS)) else $error("too many records in one step");
endmodule

/* hw/rtl/cst_queue.sv */
// cst_queue: two-entry queue of record bundles between scanner and output
// depends on cst_pkg

module cst_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  cst_pkg::bundle_type  push_data,
   input  logic                 pop,
   output logic                 full,
   output logic                 not_empty,
   output cst_pkg::bundle_type  head
);
   import cst_pkg::*;

   bundle_type mem_ff [2];
   logic       wptr_ff, rptr_ff;
   logic [1:0] count_ff;

   assign full      = count_ff == 2'd2;
   assign not_empty = count_ff != 2'd0;
   assign head      = mem_ff[rptr_ff];

   // storage
   always_ff @(posedge clock) begin
      if (push) mem_ff[wptr_ff] <= push_data;
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         if (push) wptr_ff <= !wptr_ff;
         if (pop) rptr_ff <= !rptr_ff;
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full) else $error("push into full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty) else $error("pop from empty queue");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'd2) else $error("queue count out of range");
endmodule

/* hw/rtl/cst_back.sv */
// cst_back: drains queued bundles one record per cycle while out_ready is high into the output register
// depends on cst_pkg

module cst_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 not_empty,
   input  cst_pkg::bundle_type  head,
   input  logic                 out_ready,
   output logic                 pop,
   output logic                 out_valid,
   output cst_pkg::rec_type     out_rec,
   output logic                 out_last
);
   import cst_pkg::*;

   logic [1:0] idx_ff;
   logic       valid_ff;
   rec_type    rec_ff;
   logic       last_ff;
   logic       load;
   logic       is_last;

   assign load    = not_empty && (!valid_ff || out_ready);
   assign is_last = {1'b0, idx_ff} == head.cnt - 3'd1;
   assign pop     = load && is_last;

   // record index within the head bundle, and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (load) idx_ff <= is_last ? 2'd0 : idx_ff + 2'd1;
         if (load) valid_ff <= 1'b1;
         else if (out_ready) valid_ff <= 1'b0;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (load) begin
         rec_ff <= head.recs[idx_ff];
         last_ff <= is_last;
      end
   end

   assign out_valid = valid_ff;
   assign out_rec   = rec_ff;
   assign out_last  = last_ff;

   a_idx_in_bundle: assert property (@(posedge clock) disable iff (reset)
      not_empty |-> {1'b0, idx_ff} < head.cnt) else $error("index past bundle");
   a_idx_zero_empty: assert property (@(posedge clock) disable iff (reset)
      !not_empty |-> idx_ff == 2'd0) else $error("index left over with empty queue");
   a_pop_last: assert property (@(posedge clock) disable iff (reset)
      pop |=> last_ff) else $error("bundle popped without last record");
endmodule

/* hw/rtl/c_subset_token_scanner.sv */
// c_subset_token_scanner: streaming lexer top level
// depends on cst_pkg, cst_if, cst_front, cst_queue, cst_back
//
// channel  dir  handshake        payload
// req      in   valid / ready    in_byte, end_of_input
// rsp      out  valid / ready    record_type, text_byte, token_kind, start_line,
//                                text_length, last
//
// the scanner takes one byte per cycle while the queue has room and makes zero
// to four records for it; the output drains one record per cycle while rsp.ready
// a two-bundle queue lets the scanner run ahead while the output is stalled
// reset is synchronous and clears scanner state, queue and output valid

module c_subset_token_scanner #(
   parameter int LINE_BITS   = cst_pkg::LINE_BITS_DEF,
   parameter int LENGTH_BITS = cst_pkg::LENGTH_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   cst_req_if.sink   req,
   cst_rsp_if.source rsp
);
   import cst_pkg::*;

   logic       q_full, q_not_empty, push, pop;
   bundle_type push_data, head;
   rec_type    out_rec;

   cst_front #(.LINE_BITS(LINE_BITS), .LENGTH_BITS(LENGTH_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req.valid),
      .in_byte   (req.in_byte),
      .in_eoi    (req.end_of_input),
      .q_full    (q_full),
      .in_ready  (req.ready),
      .push      (push),
      .push_data (push_data)
   );

   cst_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head      (head)
   );

   cst_back u_back (
      .clock     (clock),
      .reset     (reset),
      .not_empty (q_not_empty),
      .head      (head),
      .out_ready (rsp.ready),
      .pop       (pop),
      .out_valid (rsp.valid),
      .out_rec   (out_rec),
      .out_last  (rsp.last)
   );

   assign rsp.record_type = out_rec.rtype;
   assign rsp.text_byte   = out_rec.tb;
   assign rsp.token_kind  = out_rec.kind;
   assign rsp.start_line  = out_rec.line;
   assign rsp.text_length = out_rec.len;
endmodule

/* tb/sv/cst_tb_if.sv */
// cst_tb_pkg: testbench-side record types for the token scanner checks
// depends on nothing; the channel interfaces come from the rtl file cst_if.sv
`timescale 1ns / 1ps

package cst_tb_pkg;

   // predictor scan modes
   typedef enum logic [3:0] {
      S_IDLE, S_NUM, S_WORD, S_STR, S_STR_BS, S_LCMT, S_BCMT, S_BSTAR, S_SLASH, S_OP
   } scan_state_type;

   // one pending source request
   typedef struct packed {
      logic [7:0] ch;
      logic       eoi;
   } src_item_type;

   // one expected output record
   typedef struct packed {
      logic        rtype;
      logic [7:0]  tb;
      logic [5:0]  kind;
      logic [15:0] line;
      logic [15:0] len;
      logic        last;
   } token_rec_type;

endpackage

/* tb/sv/testbench.sv */
// testbench: random and directed checks of c_subset_token_scanner against a lexer predictor
// depends on cst_pkg, cst_tb_pkg, cst_if and the scanner rtl
`timescale 1ns / 1ps

module testbench;
   import cst_pkg::*;
   import cst_tb_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   cst_req_if req ();
   cst_rsp_if rsp ();

   c_subset_token_scanner u_top (.clock(clock), .reset(reset), .req(req), .rsp(rsp));

   always #1 clock = ~clock;

   // lexer predictor state
   scan_state_type lx_mode;
   logic [7:0]  lx_held;
   logic        lx_dot;
   logic [7:0]  lx_letters [7];
   logic [3:0]  lx_wcnt;
   logic [15:0] lx_line, lx_tok_line, lx_tok_len;

   token_rec_type expected_recs [$];
   src_item_type  pending_bytes [$];
   int          fail_count = 0;
   int          send_idle_pct = 0, recv_stall_pct = 0;
   longint      cycle_count = 0;
   bit          req_taken = 1'b0;

   function automatic void lx_clear();
      lx_mode = S_IDLE; lx_held = 0; lx_dot = 0; lx_wcnt = 0;
      lx_line = 1; lx_tok_line = 1; lx_tok_len = 0;
      for (int i = 0; i < 7; i++) lx_letters[i] = 0;
   endfunction

   function automatic void push_rec(logic rt, logic [7:0] b, logic [5:0] k,
                                    logic [15:0] ln, logic [15:0] len);
      token_rec_type r;
      r = '{rtype: rt, tb: b, kind: k, line: ln, len: len, last: 1'b0};
      expected_recs.insert(expected_recs.size(), r);
   endfunction

   function automatic void start_tok();
      lx_tok_len = 0; lx_tok_line = lx_line;
   endfunction

   function automatic void text_out(logic [7:0] b);
      push_rec(REC_TEXT, b, 6'd0, 16'd0, 16'd0);
      if (lx_tok_len != 16'hFFFF) lx_tok_len++;
   endfunction

   function automatic void close_tok(logic [5:0] k);
      push_rec(REC_END, 8'd0, k, lx_tok_line, lx_tok_len);
      lx_mode = S_IDLE;
   endfunction

   function automatic bit blank(logic [7:0] b);
      return b == " " || (b >= 8'd9 && b <= 8'd13);
   endfunction
   function automatic bit digit(logic [7:0] b);
      return b >= "0" && b <= "9";
   endfunction
   function automatic bit letter(logic [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
   endfunction

   function automatic void add_letter(logic [7:0] b);
      if (lx_wcnt < 7) lx_letters[lx_wcnt] = b;
      if (lx_wcnt < 8) lx_wcnt++;
   endfunction

   // keyword lookup on the stored letters
   function automatic logic [5:0] classify_word();
      string kw [12] = '{"int", "float", "bool", "true", "false", "if", "else",
                         "cout", "endl", "include", "main", "return"};
      bit same;
      if (lx_wcnt > 7) return K_IDENT;
      for (int i = 0; i < 12; i++) begin
         same = (kw[i].len() == int'(lx_wcnt));
         for (int j = 0; j < kw[i].len(); j++)
            if (same && kw[i][j] != lx_letters[j]) same = 1'b0;
         if (same) return 6'(int'(K_KW0) + i);
      end
      return K_IDENT;
   endfunction

   function automatic logic [5:0] op_kind(logic [7:0] c);
      case (c)
         "+": return K_PLUS;   "-": return K_MINUS;  "*": return K_STAR;
         "/": return K_SLASH;  "%": return K_PCT;    "=": return K_ASSIGN;
         "!": return K_NOT;    "<": return K_LT;     ">": return K_GT;
         "(": return K_LPAREN; ")": return K_RPAREN; "{": return K_LBRACE;
         "}": return K_RBRACE; ";": return K_SEMI;   ",": return K_COMMA;
         "#": return K_HASH;   ".": return K_DOT;
         default: return K_UNKNOWN;
      endcase
   endfunction

   // bit 6 flags a two-character operator
   function automatic logic [6:0] pair_op(logic [7:0] h, logic [7:0] b);
      if (h == "+" && b == "+") return {1'b1, K_INC};
      if (h == "-" && b == "-") return {1'b1, K_DEC};
      if (h == "=" && b == "=") return {1'b1, K_EQEQ};
      if (h == "!" && b == "=") return {1'b1, K_NEQ};
      if (h == "<" && b == "=") return {1'b1, K_LE};
      if (h == "<" && b == "<") return {1'b1, K_SHL};
      if (h == ">" && b == "=") return {1'b1, K_GE};
      if (h == "&" && b == "&") return {1'b1, K_ANDAND};
      if (h == "|" && b == "|") return {1'b1, K_OROR};
      return 7'd0;
   endfunction

   function automatic bit pair_lead(logic [7:0] b);
      return b == "+" || b == "-" || b == "=" || b == "!" ||
             b == "<" || b == ">" || b == "&" || b == "|";
   endfunction

   function automatic void between_tokens(logic [7:0] b);
      lx_mode = S_IDLE;
      if (blank(b)) return;
      start_tok();
      if (b == "/") lx_mode = S_SLASH;
      else if (b == "\"") lx_mode = S_STR;
      else if (digit(b)) begin
         lx_dot = 0; text_out(b); lx_mode = S_NUM;
      end else if (letter(b) || b == "_") begin
         lx_wcnt = 0; add_letter(b); text_out(b); lx_mode = S_WORD;
      end else if (pair_lead(b)) begin
         lx_held = b; lx_mode = S_OP;
      end else begin
         text_out(b); close_tok(op_kind(b));
      end
   endfunction

   function automatic void string_char(logic [7:0] b);
      if (b == "\"") close_tok(K_STRING);
      else if (b == "\\") lx_mode = S_STR_BS;
      else text_out(b);
   endfunction

   // expected records for one accepted request
   function automatic void lex_request(src_item_type it);
      int first;
      logic [6:0] pk;
      first = expected_recs.size();
      if (it.eoi) begin
         case (lx_mode)
            S_NUM:    close_tok(lx_dot ? K_FLOAT : K_NUMBER);
            S_WORD:   close_tok(classify_word());
            S_STR:    close_tok(K_STRING);
            S_STR_BS: begin text_out("\\"); close_tok(K_STRING); end
            S_SLASH:  begin text_out("/"); close_tok(K_SLASH); end
            S_OP:     begin text_out(lx_held); close_tok(op_kind(lx_held)); end
            default: ;
         endcase
         push_rec(REC_END, 8'd0, K_EOF, lx_line, 16'd0);
         lx_clear();
      end else begin
         if (it.ch == 8'd10 && lx_line != 16'hFFFF) lx_line++;
         case (lx_mode)
            S_NUM:
               if (digit(it.ch) || it.ch == ".") begin
                  if (it.ch == ".") lx_dot = 1;
                  text_out(it.ch);
               end else begin
                  close_tok(lx_dot ? K_FLOAT : K_NUMBER); between_tokens(it.ch);
               end
            S_WORD:
               if (letter(it.ch) || digit(it.ch) || it.ch == "_") begin
                  add_letter(it.ch); text_out(it.ch);
               end else begin
                  close_tok(classify_word()); between_tokens(it.ch);
               end
            S_STR: string_char(it.ch);
            S_STR_BS: begin
               lx_mode = S_STR;
               if (it.ch == "n") text_out(8'd10);
               else begin text_out("\\"); string_char(it.ch); end
            end
            S_LCMT: if (it.ch == 8'd10) lx_mode = S_IDLE;
            S_BCMT: if (it.ch == "*") lx_mode = S_BSTAR;
            S_BSTAR:
               if (it.ch == "/") lx_mode = S_IDLE;
               else if (it.ch != "*") lx_mode = S_BCMT;
            S_SLASH:
               if (it.ch == "/") lx_mode = S_LCMT;
               else if (it.ch == "*") lx_mode = S_BCMT;
               else begin text_out("/"); close_tok(K_SLASH); between_tokens(it.ch); end
            S_OP: begin
               pk = pair_op(lx_held, it.ch);
               text_out(lx_held);
               if (pk[6]) begin text_out(it.ch); close_tok(pk[5:0]); end
               else begin close_tok(op_kind(lx_held)); between_tokens(it.ch); end
            end
            default: between_tokens(it.ch);
         endcase
      end
      if (expected_recs.size() > first) expected_recs[$].last = 1'b1;
   endfunction

   // request and rsp.ready driver, changes at the falling edge
   initial begin
      req.valid = 0; req.in_byte = 0; req.end_of_input = 0; rsp.ready = 0;
   end

   always @(negedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
      end else if (!req.valid || req_taken) begin
         // the request shown was taken at the last rising edge, or none is shown
         if (pending_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req.valid        <= 1'b1;
            req.in_byte      <= pending_bytes[0].ch;
            req.end_of_input <= pending_bytes[0].eoi;
         end else begin
            req.valid <= 1'b0;
         end
      end
      rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // the queue head leaves when the request is accepted
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      req_taken = !reset && req.valid && req.ready;
      if (req_taken) lex_request(pending_bytes.pop_front());
   end

   // result monitor
   always @(posedge clock) begin
      token_rec_type e;
      if (!reset && rsp.valid && rsp.ready) begin
         if (expected_recs.size() == 0) begin
            $error("unexpected record type %0d kind %0d", rsp.record_type, rsp.token_kind);
            fail_count++;
         end else begin
            e = expected_recs.pop_front();
            if (rsp.record_type !== e.rtype) begin
               $error("record_type exp %0d got %0d", e.rtype, rsp.record_type); fail_count++;
            end
            if (rsp.text_byte !== e.tb) begin
               $error("text_byte exp %0h got %0h", e.tb, rsp.text_byte); fail_count++;
            end
            if (rsp.token_kind !== e.kind) begin
               $error("token_kind exp %0d got %0d", e.kind, rsp.token_kind); fail_count++;
            end
            if (rsp.start_line !== e.line) begin
               $error("start_line exp %0d got %0d", e.line, rsp.start_line); fail_count++;
            end
            if (rsp.text_length !== e.len) begin
               $error("text_length exp %0d got %0d", e.len, rsp.text_length); fail_count++;
            end
            if (rsp.last !== e.last) begin
               $error("last exp %0d got %0d", e.last, rsp.last); fail_count++;
            end
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      if (cycle_count > 200000) begin
         $display("c_subset_token_scanner verification failed");
         $finish;
      end
   end

   task automatic add_item(logic [7:0] c, logic e);
      src_item_type it;
      it.ch = c;
      it.eoi = e;
      pending_bytes.insert(pending_bytes.size(), it);
   endtask

   task automatic queue_text(string s);
      for (int i = 0; i < s.len(); i++) add_item(s[i], 1'b0);
   endtask

   task automatic queue_eoi();
      add_item(8'($urandom), 1'b1);
   endtask

   task automatic drain_all();
      while (pending_bytes.size() > 0 || expected_recs.size() > 0) @(posedge clock);
   endtask

   // random source text made of well-formed fragments and some noise
   task automatic queue_random_text(int n_bytes);
      string frags [24] = '{"int ", "float ", "bool ", "true", "false ", "if(", "else{",
         "cout<<", "endl;", "#include ", "main()", "return ", "x_1 ", "identifier9 ",
         "42 ", "3.14 ", "\"hi\\n\\t\" ", "// note\n", "/* c ** */", "a++ ", "b-- ",
         "==!=<=>=&&||", "\n", "% * / , . ! = < > & |"};
      int added;
      added = 0;
      while (added < n_bytes) begin
         if ($urandom_range(9) < 8) begin
            int k;
            k = $urandom_range(23);
            queue_text(frags[k]); added += frags[k].len();
         end else begin
            add_item(8'($urandom), 1'b0); added++;
         end
      end
      queue_eoi();
   endtask

   initial begin
      lx_clear();
      repeat (9) @(posedge clock);
      @(negedge clock) reset = 1'b0;

      // directed: keywords, operators, numbers, strings, comments, odd bytes
      queue_text("int x=3.5;if(a<=b)y++;\"s\\nq\\z\"/*k*/ //c\n");
      add_item(8'hFF, 1'b0);
      add_item(8'h01, 1'b0);
      queue_text("&|abcdefghij ");
      add_item(8'h00, 1'b0);
      queue_text("\"open\\");
      queue_eoi();
      queue_text("<"); queue_eoi();
      queue_text("/"); queue_eoi();
      queue_text("/* open"); queue_eoi();
      drain_all();

      // idle and stall phases, with a pause until all records are back between them
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 26 : 51) : 0;
         recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 26 : 51) : 0;
         queue_random_text(35);
         drain_all();
      end
      send_idle_pct = 0; recv_stall_pct = 0;
      repeat (20) @(posedge clock);

      if (fail_count == 0 && expected_recs.size() == 0)
         $display("c_subset_token_scanner verification clean");
      else
         $display("c_subset_token_scanner verification failed");
      $finish;
   end

endmodule

/* files.f */
hw/rtl/cst_pkg.sv
hw/rtl/cst_if.sv
hw/rtl/cst_front.sv
hw/rtl/cst_queue.sv
hw/rtl/cst_back.sv
hw/rtl/c_subset_token_scanner.sv
tb/sv/cst_tb_if.sv
tb/sv/testbench.sv
